// ----- hw/rtl/kte_pkg.sv -----
// ----------------------------------------------------------------------------
// kte_pkg: shared types and constants
// Table depth, entry layout and the control/status bundles between the
// controller and the datapath of the keyed timed entry table.
// ----------------------------------------------------------------------------
package kte_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

  typedef enum logic {
    CmdStore  = 1'b0,
    CmdLookup = 1'b1
  } op_e;

  typedef struct packed {
    logic [63:0]        key;
    logic [30:0]        spell;
    logic signed [31:0] start_ms;
    logic signed [31:0] end_ms;
    logic               chan;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWrite,
    StResult
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic start;     // transaction accepted, latch the item
    logic scan;      // scan in progress
    logic decide;    // scan finished this cycle
    logic write;     // commit the store
    logic out_load;  // move the result to the output register
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic chk_match;
    logic chk_last;
    logic out_busy;
  } stat_t;

endpackage

// ----- hw/rtl/kte_ram.sv -----
// ----------------------------------------------------------------------------
// kte_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/kte_ctrl.sv -----
// ----------------------------------------------------------------------------
// kte_ctrl: sequencing state machine
// Accepts a transaction, runs the table scan, then commits a store or
// hands a lookup result to the output register.
// ----------------------------------------------------------------------------
module kte_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kte_pkg::stat_t stat_i,
  output kte_pkg::ctrl_t ctrl_o
);

  kte_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kte_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      kte_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          state_d      = kte_pkg::StScan;
        end
      end
      kte_pkg::StScan: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.chk_match || stat_i.chk_last) begin
          ctrl_o.decide = 1'b1;
          state_d       = stat_i.is_lookup ? kte_pkg::StResult : kte_pkg::StWrite;
        end
      end
      kte_pkg::StWrite: begin
        ctrl_o.write = 1'b1;
        state_d      = kte_pkg::StIdle;
      end
      kte_pkg::StResult: begin
        // wait for the previous result to leave
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d         = kte_pkg::StIdle;
        end
      end
      default: begin
        state_d = kte_pkg::StIdle;
      end
    endcase
  end

endmodule

// ----- hw/rtl/kte_dpath.sv -----
// ----------------------------------------------------------------------------
// kte_dpath: table datapath
// Entry RAM, used bits, scan address and compare logic, replacement
// choice, eviction cursor and the result/output registers.
// ----------------------------------------------------------------------------
module kte_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kte_pkg::ctrl_t      ctrl_i,
  output kte_pkg::stat_t      stat_o,
  input  logic                command_i,
  input  logic [63:0]         key_i,
  input  logic [30:0]         spell_id_i,
  input  logic signed [31:0]  start_ms_i,
  input  logic signed [31:0]  end_ms_i,
  input  logic                is_channel_i,
  input  logic signed [31:0]  now_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic [30:0]         found_spell_o,
  output logic signed [31:0]  found_start_o,
  output logic signed [31:0]  found_end_o,
  output logic                found_channel_o,
  output logic                still_live_o
);

  // latched item (payload, no reset)
  logic               cmd_q;
  logic [63:0]        key_q;
  logic [30:0]        spell_q;
  logic signed [31:0] start_q, end_q, now_q;
  logic               chan_q;

  // scan control
  logic [kte_pkg::IdxW-1:0] iss_idx_q, chk_idx_q, free_idx_q, tgt_q, cursor_q;
  logic                     iss_done_q, chk_valid_q, free_found_q, evict_q;
  logic [kte_pkg::TableDepth-1:0] used_q;

  // result and output
  logic               res_hit_q, res_live_q, res_chan_q;
  logic [30:0]        res_spell_q;
  logic signed [31:0] res_start_q, res_end_q;
  logic               out_valid_q, out_hit_q, out_live_q, out_chan_q;
  logic [30:0]        out_spell_q;
  logic signed [31:0] out_start_q, out_end_q;

  kte_pkg::entry_t rd_entry, wr_entry;
  logic [kte_pkg::EntryW-1:0] rdata;
  logic rd_en, chk_used, key_eq, chk_match, chk_free, chk_last, is_lookup;

  assign is_lookup = (cmd_q == kte_pkg::CmdLookup);
  assign rd_en     = ctrl_i.scan && !iss_done_q;

  assign wr_entry = '{key: key_q, spell: spell_q, start_ms: start_q,
                      end_ms: end_q, chan: chan_q};

  kte_ram #(
    .Width (kte_pkg::EntryW),
    .Depth (kte_pkg::TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.write),
    .waddr_i (tgt_q),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (iss_idx_q),
    .rdata_o (rdata)
  );

  assign rd_entry = kte_pkg::entry_t'(rdata);

  // compare on the entry that came back from the RAM this cycle
  assign chk_used  = used_q[chk_idx_q];
  assign key_eq    = (rd_entry.key == key_q);
  // a lookup with key zero never hits
  assign chk_match = chk_valid_q && chk_used && key_eq && !(is_lookup && (key_q == 64'd0));
  assign chk_free  = chk_valid_q && (!chk_used || (now_q >= rd_entry.end_ms));
  assign chk_last  = chk_valid_q && (chk_idx_q == kte_pkg::LastIdx);

  assign stat_o = '{is_lookup: is_lookup, chk_match: chk_match,
                    chk_last: chk_last, out_busy: out_valid_q && !out_ready_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cmd_q   <= command_i;
      key_q   <= key_i;
      spell_q <= spell_id_i;
      start_q <= start_ms_i;
      end_q   <= end_ms_i;
      chan_q  <= is_channel_i;
      now_q   <= now_ms_i;
    end
    if (rd_en) begin
      chk_idx_q <= iss_idx_q;
    end
    if (ctrl_i.scan && chk_free && !free_found_q) begin
      free_idx_q <= chk_idx_q;
    end
    if (ctrl_i.decide) begin
      if (chk_match) begin
        tgt_q <= chk_idx_q;
      end else if (free_found_q) begin
        tgt_q <= free_idx_q;
      end else if (chk_free) begin
        tgt_q <= chk_idx_q;
      end else begin
        tgt_q <= cursor_q;
      end
      res_hit_q   <= chk_match;
      res_spell_q <= chk_match ? rd_entry.spell : '0;
      res_start_q <= chk_match ? rd_entry.start_ms : '0;
      res_end_q   <= chk_match ? rd_entry.end_ms : '0;
      res_chan_q  <= chk_match && rd_entry.chan;
      res_live_q  <= chk_match && (now_q < rd_entry.end_ms);
    end
    if (ctrl_i.out_load) begin
      out_hit_q   <= res_hit_q;
      out_spell_q <= res_spell_q;
      out_start_q <= res_start_q;
      out_end_q   <= res_end_q;
      out_chan_q  <= res_chan_q;
      out_live_q  <= res_live_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_idx_q    <= '0;
      iss_done_q   <= 1'b1;
      chk_valid_q  <= 1'b0;
      free_found_q <= 1'b0;
      evict_q      <= 1'b0;
      cursor_q     <= '0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctrl_i.start) begin
        iss_idx_q    <= '0;
        iss_done_q   <= 1'b0;
        chk_valid_q  <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        chk_valid_q <= rd_en;
        if (rd_en) begin
          iss_idx_q <= iss_idx_q + 1'b1;
          if (iss_idx_q == kte_pkg::LastIdx) begin
            iss_done_q <= 1'b1;
          end
        end
        if (ctrl_i.scan && chk_free) begin
          free_found_q <= 1'b1;
        end
      end
      if (ctrl_i.decide) begin
        evict_q <= !chk_match && !free_found_q && !chk_free;
      end
      if (ctrl_i.write) begin
        used_q[tgt_q] <= 1'b1;
        if (evict_q) begin
          cursor_q <= (cursor_q == kte_pkg::LastIdx) ? '0 : cursor_q + 1'b1;
        end
      end
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign found_spell_o   = out_spell_q;
  assign found_start_o   = out_start_q;
  assign found_end_o     = out_end_q;
  assign found_channel_o = out_chan_q;
  assign still_live_o    = out_live_q;

endmodule

// ----- hw/rtl/keyed_timed_entry_table.sv -----
// ----------------------------------------------------------------------------
// keyed_timed_entry_table: associative timed entry table
// Store/lookup of entries keyed by a 64-bit caster identifier, with
// expiry-aware fill and round-robin eviction.
// ----------------------------------------------------------------------------
// Sequencing: from acceptance to store commit or result in the output
//   register, the scan reads one entry per cycle through the single read
//   port of the entry RAM and stops at the first key match. A lookup also
//   waits while the output register still holds an unaccepted result.
// Flow: one transaction at a time; a new one is taken while a finished
//   result still waits in the output register.
// Reset: used bits, eviction cursor and all control clear at once; the entry
//   RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module keyed_timed_entry_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input transactions
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [63:0]        key_i,
  input  logic [30:0]        spell_id_i,
  input  logic signed [31:0] start_ms_i,
  input  logic signed [31:0] end_ms_i,
  input  logic               is_channel_i,
  input  logic signed [31:0] now_ms_i,
  // lookup results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [30:0]        found_spell_o,
  output logic signed [31:0] found_start_o,
  output logic signed [31:0] found_end_o,
  output logic               found_channel_o,
  output logic               still_live_o
);

  // command and status between sequencer and datapath
  kte_pkg::ctrl_t ctrl;
  kte_pkg::stat_t stat;

  // Sequencer: idle -> scan -> (write | result) -> idle.
  kte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Datapath: entry RAM, used bits, compare, replacement choice and the
  // output register that decouples the result from the next transaction.
  kte_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (command_i),
    .key_i           (key_i),
    .spell_id_i      (spell_id_i),
    .start_ms_i      (start_ms_i),
    .end_ms_i        (end_ms_i),
    .is_channel_i    (is_channel_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .found_spell_o   (found_spell_o),
    .found_start_o   (found_start_o),
    .found_end_o     (found_end_o),
    .found_channel_o (found_channel_o),
    .still_live_o    (still_live_o)
  );

endmodule

// ----- test/tb_keyed_timed_entry_table.sv -----
// ----------------------------------------------------------------------------
// tb_keyed_timed_entry_table: self-checking testbench for the entry table
// Drives store and lookup transactions through a queued driver, keeps its own
// copy of the table to predict every lookup answer, and checks each returned
// result field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_keyed_timed_entry_table;
  import kte_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned PoolSize   = 128;
  localparam int unsigned HotKeys    = 8;
  localparam int unsigned FillBurst  = 70;   // more than the depth: forces eviction
  localparam int unsigned PhaseItems = 250;

  // pacing of the two channels
  typedef enum int unsigned {
    PhFree,
    PhSendIdle,
    PhRecvStall,
    PhBothIdle
  } pace_e;

  typedef struct {
    op_e                cmd;
    logic [63:0]        key;
    logic [30:0]        spell;
    logic signed [31:0] start_ms;
    logic signed [31:0] end_ms;
    logic               chan;
    logic signed [31:0] now_ms;
    pace_e              pace;
  } cast_item_t;

  typedef struct {
    logic               hit;
    logic [30:0]        spell;
    logic signed [31:0] start_ms;
    logic signed [31:0] end_ms;
    logic               chan;
    logic               live;
  } lookup_answer_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // stimulus side, all known from time zero
  logic               in_valid   = 1'b0;
  logic               command    = 1'b0;
  logic [63:0]        key        = '0;
  logic [30:0]        spell_id   = '0;
  logic signed [31:0] start_ms   = '0;
  logic signed [31:0] end_ms     = '0;
  logic               is_channel = 1'b0;
  logic signed [31:0] now_ms     = '0;
  logic               out_ready  = 1'b0;
  pace_e              run_pace   = PhFree;

  logic               in_ready_o;
  logic               out_valid_o;
  logic               hit_o;
  logic [30:0]        found_spell_o;
  logic signed [31:0] found_start_o;
  logic signed [31:0] found_end_o;
  logic               found_channel_o;
  logic               still_live_o;

  keyed_timed_entry_table DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .command_i       (command),
    .key_i           (key),
    .spell_id_i      (spell_id),
    .start_ms_i      (start_ms),
    .end_ms_i        (end_ms),
    .is_channel_i    (is_channel),
    .now_ms_i        (now_ms),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .hit_o           (hit_o),
    .found_spell_o   (found_spell_o),
    .found_start_o   (found_start_o),
    .found_end_o     (found_end_o),
    .found_channel_o (found_channel_o),
    .still_live_o    (still_live_o)
  );

  cast_item_t     cast_queue[$];      // transactions not yet offered
  lookup_answer_t lookup_answers[$];  // predicted answers, oldest first
  int unsigned    mismatch_cnt = 0;
  int unsigned    cycle_cnt    = 0;

  // ---------------------------------------------------------------------------
  // Shadow of the table: entries, used bits and the eviction cursor.
  // ---------------------------------------------------------------------------
  entry_t          shadow_entry [TableDepth];
  logic            shadow_used  [TableDepth];
  logic [IdxW-1:0] shadow_cursor;

  initial begin
    for (int i = 0; i < TableDepth; i++) shadow_used[i] = 1'b0;
    shadow_cursor = '0;
  end

  // Apply one accepted transaction to the shadow table; a lookup queues its
  // answer.
  task automatic table_apply(input cast_item_t it);
    int             slot;
    lookup_answer_t ans;
    slot = -1;
    ans  = '{default: '0};
    if (it.cmd == CmdStore) begin
      // same key already held: overwrite in place
      for (int i = 0; i < TableDepth && slot < 0; i++)
        if (shadow_used[i] && shadow_entry[i].key == it.key) slot = i;
      // else first free or expired slot (signed time compare)
      for (int i = 0; i < TableDepth && slot < 0; i++)
        if (!shadow_used[i] || $signed(it.now_ms) >= $signed(shadow_entry[i].end_ms))
          slot = i;
      // else round-robin victim
      if (slot < 0) begin
        slot = int'(shadow_cursor);
        shadow_cursor = (shadow_cursor == LastIdx) ? '0 : shadow_cursor + 1'b1;
      end
      shadow_entry[slot].key      = it.key;
      shadow_entry[slot].spell    = it.spell;
      shadow_entry[slot].start_ms = it.start_ms;
      shadow_entry[slot].end_ms   = it.end_ms;
      shadow_entry[slot].chan     = it.chan;
      shadow_used[slot]           = 1'b1;
    end else begin
      // key zero never hits; a miss answers all zero
      if (it.key != '0)
        for (int i = 0; i < TableDepth && slot < 0; i++)
          if (shadow_used[i] && shadow_entry[i].key == it.key) slot = i;
      if (slot >= 0) begin
        ans.hit      = 1'b1;
        ans.spell    = shadow_entry[slot].spell;
        ans.start_ms = shadow_entry[slot].start_ms;
        ans.end_ms   = shadow_entry[slot].end_ms;
        ans.chan     = shadow_entry[slot].chan;
        ans.live     = $signed(it.now_ms) < $signed(shadow_entry[slot].end_ms);
      end
      lookup_answers.push_back(ans);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  logic [63:0]        key_pool [PoolSize];
  logic signed [31:0] game_ms;   // slowly advancing game clock

  function automatic cast_item_t make_cast(op_e cmd, logic [63:0] k, logic [30:0] sp,
                                           logic signed [31:0] st, logic signed [31:0] en,
                                           logic ch, logic signed [31:0] nw, pace_e pc);
    cast_item_t it;
    it.cmd      = cmd;
    it.key      = k;
    it.spell    = sp;
    it.start_ms = st;
    it.end_ms   = en;
    it.chan     = ch;
    it.now_ms   = nw;
    it.pace     = pc;
    return it;
  endfunction

  // Mostly keys from a small hot set so lookups hit; some pool keys to fill
  // the table, a few wild keys and key zero.
  function automatic cast_item_t random_cast(pace_e pc);
    cast_item_t  it;
    int unsigned r;
    it.pace = pc;
    it.cmd  = $urandom_range(1) ? CmdLookup : CmdStore;
    r = $urandom_range(99);
    if (r < 5)       it.key = '0;
    else if (r < 10) it.key = {$urandom, $urandom};
    else if (r < 65) it.key = key_pool[$urandom_range(HotKeys - 1)];
    else             it.key = key_pool[$urandom_range(PoolSize - 1)];
    it.spell = 31'($urandom);
    it.chan  = 1'($urandom_range(1));
    game_ms  = game_ms + $urandom_range(20);
    r = $urandom_range(99);
    if (r < 45)      it.end_ms = game_ms + $urandom_range(1000000, 100000);  // long-lived
    else if (r < 75) it.end_ms = game_ms + $urandom_range(300);              // short
    else if (r < 85) it.end_ms = game_ms - $urandom_range(100, 1);           // already over
    else             it.end_ms = $urandom;
    it.start_ms = ($urandom_range(4) != 0) ? game_ms - $urandom_range(500) : $urandom;
    it.now_ms   = ($urandom_range(9) != 0) ? game_ms : $urandom;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued transactions, predicts each one as it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    cast_item_t  inflight;
    bit          busy;
    int unsigned idle_pct;
    if (rst_ni) begin
      busy = in_valid;
      if (in_valid && in_ready_o) begin
        table_apply(inflight);
        busy = 1'b0;
      end
      if (!busy) begin
        idle_pct = 0;
        if (cast_queue.size() != 0) begin
          run_pace <= cast_queue[0].pace;
          case (cast_queue[0].pace)
            PhSendIdle: idle_pct = 67;
            PhBothIdle: idle_pct = 28;
            default:    idle_pct = 0;
          endcase
        end
        if (cast_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          inflight = cast_queue.pop_front();
          command    <= inflight.cmd;
          key        <= inflight.key;
          spell_id   <= inflight.spell;
          start_ms   <= inflight.start_ms;
          end_ms     <= inflight.end_ms;
          is_channel <= inflight.chan;
          now_ms     <= inflight.now_ms;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, compares results against the oldest answer.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : watch_proc
    lookup_answer_t want;
    int unsigned    stall_pct;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (lookup_answers.size() == 0) begin
          $error("result transaction with no lookup outstanding");
          mismatch_cnt++;
        end else begin
          want = lookup_answers.pop_front();
          check_field("hit",           64'(want.hit),      64'(hit_o));
          check_field("found_spell",   64'(want.spell),    64'(found_spell_o));
          check_field("found_start",   64'(want.start_ms), 64'(found_start_o));
          check_field("found_end",     64'(want.end_ms),   64'(found_end_o));
          check_field("found_channel", 64'(want.chan),     64'(found_channel_o));
          check_field("still_live",    64'(want.live),     64'(still_live_o));
        end
      end
      case (run_pace)
        PhRecvStall: stall_pct = 67;
        PhBothIdle:  stall_pct = 28;
        default:     stall_pct = 0;
      endcase
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed checks, then four paced phases of random traffic.
  // ---------------------------------------------------------------------------
  initial begin : sequence_proc
    int unsigned base;
    pace_e       pc;

    for (int i = 0; i < PoolSize; i++) key_pool[i] = {$urandom, $urandom} | 64'd1;
    game_ms = $urandom;

    // empty table misses, key zero misses even when stored
    cast_queue.push_back(make_cast(CmdLookup, 64'd1, '0, '0, '0, 1'b0, '0, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, '0, '0, '0, '0, 1'b0, '0, PhFree));
    cast_queue.push_back(make_cast(CmdStore, '0, '1, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                   1'b1, 32'sh8000_0000, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, '0, '0, '0, '0, 1'b0, '0, PhFree));
    // all-ones key with extreme times; live edge at the end time
    cast_queue.push_back(make_cast(CmdStore, '1, '1, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                   1'b1, 32'sh8000_0000, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, '1, '0, '0, '0, 1'b0, 32'sh7FFF_FFFE, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, '1, '0, '0, '0, 1'b0, 32'sh7FFF_FFFF, PhFree));
    // same key again overwrites in place
    cast_queue.push_back(make_cast(CmdStore, '1, 31'h2AAA_AAAA, 32'sh7FFF_FFFF,
                                   32'sh8000_0000, 1'b0, 32'sh7FFF_FFFF, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, '1, '1, '1, '1, 1'b1, 32'sh8000_0000, PhFree));
    // expired entry is reused by the next new key
    cast_queue.push_back(make_cast(CmdStore, 64'd5, 31'd5, 32'sd0, 32'sh8000_0000,
                                   1'b1, 32'sd0, PhFree));
    cast_queue.push_back(make_cast(CmdStore, 64'd6, 31'd6, 32'sd1, 32'sd100,
                                   1'b0, 32'sd0, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, 64'd5, '0, '0, '0, 1'b0, 32'sd0, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, 64'd6, '0, '0, '0, 1'b0, 32'sd99, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, 64'd6, '0, '0, '0, 1'b0, 32'sd100, PhFree));
    // all-zero payload, live flag around end time zero
    cast_queue.push_back(make_cast(CmdStore, 64'd7, '0, '0, '0, 1'b0, 32'sh8000_0000, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, 64'd7, '0, '0, '0, 1'b0, -32'sd1, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, 64'd7, '0, '0, '0, 1'b0, 32'sd0, PhFree));
    cast_queue.push_back(make_cast(CmdLookup, 64'd8, '0, '0, '0, 1'b0, 32'sd0, PhFree));

    for (int p = 0; p < 4; p++) begin
      pc = pace_e'(p);
      // burst of distinct long-lived keys to fill the table and wrap the cursor
      base = $urandom_range(PoolSize - 1);
      for (int j = 0; j < FillBurst; j++)
        cast_queue.push_back(make_cast(CmdStore, key_pool[(base + j) % PoolSize],
                                       31'($urandom), game_ms,
                                       32'sh7FFF_FFFF - $urandom_range(1000),
                                       1'($urandom_range(1)), game_ms, pc));
      for (int j = 0; j < PhaseItems - FillBurst; j++)
        cast_queue.push_back(random_cast(pc));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything offered, accepted and answered
    while (cast_queue.size() != 0 || in_valid || lookup_answers.size() != 0)
      @(posedge clk_i);
    // stores finishing late, and any stray result, show up in this window
    repeat (2 * TableDepth + 16) @(posedge clk_i);

    if (mismatch_cnt == 0 && lookup_answers.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- keyed_timed_entry_table.f -----
hw/rtl/kte_pkg.sv
hw/rtl/kte_ram.sv
hw/rtl/kte_ctrl.sv
hw/rtl/kte_dpath.sv
hw/rtl/keyed_timed_entry_table.sv
test/tb_keyed_timed_entry_table.sv
